FILE: rtl/cfr_pkg.sv
// ============================================================================
// cfr_pkg: shared types and constants of the CRC-checked frame receiver
// Result kinds, header byte positions, CRC seeds and the byte-wise CRC8 and
// CRC16 update functions.
// ============================================================================
package cfr_pkg;

    // Classification of each received byte.
    typedef enum logic [2:0] {
        KIND_IGNORED   = 3'd0,
        KIND_HEADER    = 3'd1,
        KIND_PAYLOAD   = 3'd2,
        KIND_TAIL      = 3'd3,
        KIND_GOOD      = 3'd4,
        KIND_CRC16_BAD = 3'd5,
        KIND_CRC8_BAD  = 3'd6,
        KIND_TOO_LONG  = 3'd7
    } t_kind;

    // One result item as it leaves the deframer.
    typedef struct packed {
        t_kind        kind;
        logic [7:0]   data_byte;
        logic [7:0]   payload_index;
        logic [15:0]  command_id;
        logic [7:0]   sequence_res;
        logic [16:0]  frame_length;
    } t_result;

    // Byte positions inside the frame.
    localparam logic [15:0] POS_LEN_LO   = 16'd1;
    localparam logic [15:0] POS_LEN_HI   = 16'd2;
    localparam logic [15:0] POS_SEQ      = 16'd3;
    localparam logic [15:0] POS_HDR_CRC  = 16'd4;
    localparam logic [15:0] POS_CMD_LO   = 16'd5;
    localparam logic [15:0] POS_CMD_HI   = 16'd6;
    localparam logic [7:0]  PAYLOAD_BASE = 8'd7;

    // Header plus command id plus CRC16 bytes around the payload.
    localparam logic [16:0] FRAME_OVERHEAD = 17'd9;

    localparam logic [7:0]  START_BYTE_RESET = 8'hA5;
    localparam logic [7:0]  CRC8_SEED        = 8'hFF;
    localparam logic [15:0] CRC16_SEED       = 16'hFFFF;
    localparam logic [7:0]  CRC8_POLY_REF    = 8'h8C;
    localparam logic [15:0] CRC16_POLY_REF   = 16'h8408;

    // Reflected CRC8 (x^8+x^5+x^4+1), one byte.
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] x;
        x = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            x = x[0] ? ((x >> 1) ^ CRC8_POLY_REF) : (x >> 1);
        end
        return x;
    endfunction

    // Reflected CCITT CRC16, one byte.
    function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] x;
        x = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            x = x[0] ? ((x >> 1) ^ CRC16_POLY_REF) : (x >> 1);
        end
        return x;
    endfunction

endpackage

FILE: rtl/cfr_deframer.sv
// ============================================================================
// cfr_deframer: frame state machine and byte classifier
// Holds the frame state, updates both CRCs and classifies one registered
// byte per enabled cycle.
// ============================================================================
module cfr_deframer #(
    parameter int MAX_FRAME = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [7:0]        i_byte,
    input  logic [7:0]        i_start_byte,
    output cfr_pkg::t_result  o_result
);
    import cfr_pkg::*;

    localparam logic [16:0] MaxFrameW = 17'(MAX_FRAME);

    logic        r_receiving,    n_receiving;
    logic [15:0] r_byte_count,   n_byte_count;
    logic [16:0] r_total_length, n_total_length;
    logic [7:0]  r_header_crc,   n_header_crc;
    logic [15:0] r_frame_crc,    n_frame_crc;
    logic [7:0]  r_seq_held,     n_seq_held;
    logic [15:0] r_cmd_held,     n_cmd_held;
    logic [7:0]  r_tail_low,     n_tail_low;

    logic [16:0] w_pos_p2;
    logic [16:0] w_total_lin;
    logic        w_active;
    logic        w_known;
    t_kind       w_kind;
    logic [7:0]  w_pidx;

    assign w_pos_p2    = {1'b0, r_byte_count} + 17'd2;
    assign w_total_lin = {1'b0, r_total_length[15:0]} + FRAME_OVERHEAD;

    // Next state and classification of the current byte.
    always_comb begin
        n_receiving    = r_receiving;
        n_byte_count   = r_byte_count;
        n_total_length = r_total_length;
        n_header_crc   = r_header_crc;
        n_frame_crc    = r_frame_crc;
        n_seq_held     = r_seq_held;
        n_cmd_held     = r_cmd_held;
        n_tail_low     = r_tail_low;
        w_kind         = KIND_IGNORED;
        w_pidx         = 8'd0;
        w_active       = 1'b0;
        w_known        = 1'b0;

        if (!r_receiving) begin
            if (i_byte == i_start_byte) begin
                n_receiving    = 1'b1;
                n_byte_count   = 16'd1;
                n_header_crc   = crc8_next(CRC8_SEED, i_byte);
                n_frame_crc    = crc16_next(CRC16_SEED, i_byte);
                n_total_length = 17'd0;
                n_seq_held     = 8'd0;
                n_cmd_held     = 16'd0;
                n_tail_low     = 8'd0;
                w_kind         = KIND_HEADER;
                w_active       = 1'b1;
            end
        end else begin
            w_active     = 1'b1;
            n_byte_count = r_byte_count + 16'd1;
            if (r_byte_count < POS_HDR_CRC) begin
                // Header bytes before the CRC8.
                n_header_crc = crc8_next(r_header_crc, i_byte);
                n_frame_crc  = crc16_next(r_frame_crc, i_byte);
                if (r_byte_count == POS_LEN_LO) begin
                    n_total_length = {9'd0, i_byte};
                end else if (r_byte_count == POS_LEN_HI) begin
                    n_total_length = {1'b0, i_byte, r_total_length[7:0]};
                end else if (r_byte_count == POS_SEQ) begin
                    n_seq_held = i_byte;
                end
                w_kind = KIND_HEADER;
            end else if (r_byte_count == POS_HDR_CRC) begin
                // Header CRC8 check and length limit.
                if (i_byte != r_header_crc) begin
                    w_kind      = KIND_CRC8_BAD;
                    n_receiving = 1'b0;
                end else begin
                    n_total_length = w_total_lin;
                    n_frame_crc    = crc16_next(r_frame_crc, i_byte);
                    w_known        = 1'b1;
                    if (w_total_lin > MaxFrameW) begin
                        w_kind      = KIND_TOO_LONG;
                        n_receiving = 1'b0;
                    end else begin
                        w_kind = KIND_HEADER;
                    end
                end
            end else begin
                w_known = 1'b1;
                if (w_pos_p2 < r_total_length) begin
                    // Command id and payload bytes.
                    n_frame_crc = crc16_next(r_frame_crc, i_byte);
                    if (r_byte_count == POS_CMD_LO) begin
                        n_cmd_held = {8'd0, i_byte};
                        w_kind     = KIND_HEADER;
                    end else if (r_byte_count == POS_CMD_HI) begin
                        n_cmd_held = {i_byte, r_cmd_held[7:0]};
                        w_kind     = KIND_HEADER;
                    end else begin
                        w_kind = KIND_PAYLOAD;
                        w_pidx = r_byte_count[7:0] - PAYLOAD_BASE;
                    end
                end else if (w_pos_p2 == r_total_length) begin
                    n_tail_low = i_byte;
                    w_kind     = KIND_TAIL;
                end else begin
                    // Last byte: compare the received CRC16 with the running one.
                    if ((r_tail_low == r_frame_crc[7:0]) && (i_byte == r_frame_crc[15:8])) begin
                        w_kind = KIND_GOOD;
                    end else begin
                        w_kind = KIND_CRC16_BAD;
                    end
                    n_receiving = 1'b0;
                end
            end
        end
    end

    // Result fields taken from the state as it stands after this byte.
    always_comb begin
        o_result.kind          = w_kind;
        o_result.data_byte     = i_byte;
        o_result.payload_index = w_pidx;
        o_result.command_id    = w_active ? n_cmd_held : 16'd0;
        o_result.sequence_res  = w_active ? n_seq_held : 8'd0;
        o_result.frame_length  = w_known ? n_total_length : 17'd0;
    end

    // Frame state registers, updated once per processed byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_receiving    <= 1'b0;
            r_byte_count   <= 16'd0;
            r_total_length <= 17'd0;
            r_header_crc   <= CRC8_SEED;
            r_frame_crc    <= CRC16_SEED;
            r_seq_held     <= 8'd0;
            r_cmd_held     <= 16'd0;
            r_tail_low     <= 8'd0;
        end else if (i_en) begin
            r_receiving    <= n_receiving;
            r_byte_count   <= n_byte_count;
            r_total_length <= n_total_length;
            r_header_crc   <= n_header_crc;
            r_frame_crc    <= n_frame_crc;
            r_seq_held     <= n_seq_held;
            r_cmd_held     <= n_cmd_held;
            r_tail_low     <= n_tail_low;
        end
    end

    // A payload byte only appears inside a frame whose length passed the limit.
    a_payload_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && (w_kind == KIND_PAYLOAD)) |-> (r_receiving && (r_total_length <= MaxFrameW)))
        else $error("payload byte outside an accepted frame");

    // A frame ending byte always drops the block back to hunting.
    a_end_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && (w_kind == KIND_GOOD || w_kind == KIND_CRC16_BAD ||
                  w_kind == KIND_CRC8_BAD || w_kind == KIND_TOO_LONG)) |=> !r_receiving)
        else $error("frame end did not return to hunting");

    // An ignored byte leaves the frame state untouched.
    a_ignored_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && (w_kind == KIND_IGNORED)) |=> (!r_receiving && $stable(r_byte_count)))
        else $error("ignored byte changed the frame state");

endmodule

FILE: rtl/crc_checked_frame_receiver_unit.sv
// ============================================================================
// crc_checked_frame_receiver_unit: start/length/CRC8/CRC16 frame receiver
// Input and output registers around the deframer, plus the start byte
// register.
// ============================================================================
// Usage:
// Received link bytes enter on the slave stream (i_s_*), one byte per item.
// Every accepted byte gives exactly one result item on the master stream
// (o_m_*): its kind in tuser, and the byte, payload index, command id,
// sequence number and total frame length in tdata.
// The start byte register is written through i_cfg_wr_en / i_cfg_wr_data
// only while the stream is idle; the user must keep to this, as the block
// itself does not enforce it. It resets to 0xA5. An accepted item is held
// in the input register and then registered in the output register. One
// item is accepted in every cycle while the output is not stalled; the rate
// is set by the single pass through the deframer's CRC and compare logic
// between the input and output registers.
// When the receiver holds tready low, the output register keeps its item,
// the input register fills, and then o_s_tready drops until space frees.
// Synchronous active-low reset empties both registers, returns the deframer
// to hunting for a start byte and restores the start byte to 0xA5.
// ============================================================================
module crc_checked_frame_receiver_unit #(
    parameter int MAX_FRAME = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave stream: tdata = rx_byte[7:0]
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,
    // Master stream: tdata = data_byte[7:0], payload_index[15:8],
    // command_id[31:16], sequence_res[39:32], frame_length[56:40], zeros[63:57]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,
    // Master stream: tuser = kind[2:0]
    output logic [2:0]  o_m_tuser,
    // Start byte register write
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data
);
    import cfr_pkg::*;

    logic       r_start_byte;
    logic [7:0] r_start_val;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    t_result    w_result;
    logic       w_out_free;
    logic       w_process;

    // Output register can take a new item when empty or being drained.
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_process  = r_in_valid && w_out_free;
    assign o_s_tready = !r_in_valid || w_out_free;

    // Start byte configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= 1'b0;
            r_start_val  <= START_BYTE_RESET;
        end else if (i_cfg_wr_en) begin
            r_start_byte <= 1'b1;
            r_start_val  <= i_cfg_wr_data;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
    end

    cfr_deframer #(
        .MAX_FRAME (MAX_FRAME)
    ) u_deframer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_process),
        .i_byte       (r_in_byte),
        .i_start_byte (r_start_val),
        .o_result     (w_result)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_process) begin
            r_out <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tdata  = {7'd0, r_out.frame_length, r_out.sequence_res,
                         r_out.command_id, r_out.payload_index, r_out.data_byte};

    // A held input item stays until the output side frees up.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_out_free) |=> r_in_valid)
        else $error("input item lost while output stalled");

    // Every processed item appears in the output register next cycle.
    a_out_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_process |=> r_out_valid)
        else $error("processed item did not reach the output register");

    // A written start byte is the one the deframer compares against.
    a_cfg_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en |=> (r_start_byte && (r_start_val == $past(i_cfg_wr_data))))
        else $error("start byte write not taken");

endmodule
